// ===== src/lsfp_pkg.sv =====
package lsfp_pkg;

  // Default strip layout.
  localparam int NumPixelsDefault      = 116;
  localparam int RightRunnerLenDefault = 44;
  localparam int RightIndLenDefault    = 14;
  localparam int LeftIndLenDefault     = 14;

  // Field widths fixed by the interface.
  localparam int PairW   = 6;
  localparam int PixW    = PairW + 1;
  localparam int ChanW   = 8;
  localparam int PeriodW = 16;

  localparam logic [PeriodW-1:0] BlinkPeriodReset = 16'd500;
  localparam logic [7:0]         PatternLimit     = 8'd3;
  localparam logic [ChanW-1:0]   ChanFull         = 8'hff;
  localparam logic [ChanW-1:0]   WheelThird       = 8'd85;
  localparam logic [ChanW-1:0]   WheelTwoThirds   = 8'd170;

  // Depth of the frame queue between front and back.
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    PAT_OFF     = 2'd0,
    PAT_RAINBOW = 2'd1,
    PAT_BREATH  = 2'd2
  } pattern_e;

  typedef enum logic [1:0] {
    IND_OFF    = 2'd0,
    IND_LEFT   = 2'd1,
    IND_RIGHT  = 2'd2,
    IND_HAZARD = 2'd3
  } ind_mode_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // Everything the back end needs to paint one frame.
  typedef struct packed {
    pattern_e         pattern;
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] level;
    logic             lit;
    ind_mode_e        mode;
  } frame_desc_t;

  // Three-segment colour wheel.
  function automatic rgb_t colour_wheel(logic [ChanW-1:0] h);
    rgb_t             c;
    logic [ChanW-1:0] hh;
    logic [9:0]       prod;
    logic [ChanW-1:0] ramp;
    if (h < WheelThird) begin
      hh = h;
    end else if (h < WheelTwoThirds) begin
      hh = h - WheelThird;
    end else begin
      hh = h - WheelTwoThirds;
    end
    prod = {2'b00, hh} * 10'd3;
    ramp = prod[ChanW-1:0];
    if (h < WheelThird) begin
      c.red   = ramp;
      c.green = ChanFull - ramp;
      c.blue  = '0;
    end else if (h < WheelTwoThirds) begin
      c.red   = ChanFull - ramp;
      c.green = '0;
      c.blue  = ramp;
    end else begin
      c.red   = '0;
      c.green = ramp;
      c.blue  = ChanFull - ramp;
    end
    return c;
  endfunction

endpackage

// ===== src/lsfp_queue.sv =====
module lsfp_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  lsfp_pkg::frame_desc_t  push_desc_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   head_valid_o,
  output lsfp_pkg::frame_desc_t  head_desc_o
);

  localparam int PtrW = (lsfp_pkg::QueueDepth > 1) ? $clog2(lsfp_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(lsfp_pkg::QueueDepth + 1);

  lsfp_pkg::frame_desc_t slot_q [lsfp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o       = (count_q == CntW'(lsfp_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_desc_o  = slot_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(lsfp_pkg::QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

// ===== src/lsfp_front.sv =====
module lsfp_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  blink_period_ms_we_i,
  input  logic [lsfp_pkg::PeriodW-1:0]          blink_period_ms_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [7:0]                            pattern_request_i,
  input  logic [1:0]                            indicator_mode_i,
  input  logic [15:0]                           elapsed_ms_i,
  input  logic                                  queue_full_i,
  output logic                                  push_o,
  output lsfp_pkg::frame_desc_t                 push_desc_o
);

  logic [lsfp_pkg::PeriodW-1:0] period_q;
  lsfp_pkg::pattern_e           pattern_q, pattern_d;
  logic [7:0]                   hue_q, hue_d;
  logic [7:0]                   level_q, level_d;
  logic                         rising_q, rising_d;
  logic                         lit_q, lit_d;
  logic [15:0]                  accum_q, accum_d;
  logic [16:0]                  accum_sum;
  logic [15:0]                  accum_sat;
  logic                         accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    pattern_d = pattern_q;
    if (pattern_request_i < lsfp_pkg::PatternLimit) begin
      pattern_d = lsfp_pkg::pattern_e'(pattern_request_i[1:0]);
    end

    hue_d    = hue_q;
    level_d  = level_q;
    rising_d = rising_q;
    case (pattern_d)
      lsfp_pkg::PAT_RAINBOW: begin
        hue_d = hue_q + 8'd1;
      end
      lsfp_pkg::PAT_BREATH: begin
        if (rising_q) begin
          level_d = level_q + 8'd1;
          if (level_d == lsfp_pkg::ChanFull) begin
            rising_d = 1'b0;
          end
        end else begin
          level_d = level_q - 8'd1;
          if (level_d == '0) begin
            rising_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // The blink accumulator saturates rather than wrapping.
    accum_sum = {1'b0, accum_q} + {1'b0, elapsed_ms_i};
    accum_sat = accum_sum[16] ? 16'hffff : accum_sum[15:0];
    if (accum_sat >= period_q) begin
      lit_d   = !lit_q;
      accum_d = '0;
    end else begin
      lit_d   = lit_q;
      accum_d = accum_sat;
    end

    // The rainbow paints with the hue from before its advance.
    push_desc_o.pattern = pattern_d;
    push_desc_o.hue     = hue_q;
    push_desc_o.level   = level_d;
    push_desc_o.lit     = lit_d;
    push_desc_o.mode    = lsfp_pkg::ind_mode_e'(indicator_mode_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= lsfp_pkg::BlinkPeriodReset;
      pattern_q <= lsfp_pkg::PAT_OFF;
      hue_q     <= '0;
      level_q   <= '0;
      rising_q  <= 1'b1;
      lit_q     <= 1'b1;
      accum_q   <= '0;
    end else begin
      if (blink_period_ms_we_i) begin
        period_q <= blink_period_ms_i;
      end
      if (accept) begin
        pattern_q <= pattern_d;
        hue_q     <= hue_d;
        level_q   <= level_d;
        rising_q  <= rising_d;
        lit_q     <= lit_d;
        accum_q   <= accum_d;
      end
    end
  end

endmodule

// ===== src/lsfp_back.sv =====
module lsfp_back #(
  parameter int NUM_PIXELS       = lsfp_pkg::NumPixelsDefault,
  parameter int RIGHT_RUNNER_LEN = lsfp_pkg::RightRunnerLenDefault,
  parameter int RIGHT_IND_LEN    = lsfp_pkg::RightIndLenDefault,
  parameter int LEFT_IND_LEN     = lsfp_pkg::LeftIndLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  lsfp_pkg::frame_desc_t         head_desc_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lsfp_pkg::PairW-1:0]    pair_index_o,
  output logic [7:0]                    red_even_o,
  output logic [7:0]                    green_even_o,
  output logic [7:0]                    blue_even_o,
  output logic [7:0]                    red_odd_o,
  output logic [7:0]                    green_odd_o,
  output logic [7:0]                    blue_odd_o,
  output logic                          last_pair_o
);

  localparam int Pairs   = (NUM_PIXELS + 1) / 2;
  localparam int StepQ   = 256 / NUM_PIXELS;
  localparam int StepR   = 256 % NUM_PIXELS;
  localparam int Step2Q  = 512 / NUM_PIXELS;
  localparam int Step2R  = 512 % NUM_PIXELS;
  localparam int RemW    = $clog2(NUM_PIXELS + 1);
  localparam int SegW    = 9;
  localparam int RightLo = RIGHT_RUNNER_LEN;
  localparam int RightHi = RightLo + RIGHT_IND_LEN;
  localparam int LeftHi  = RightHi + LEFT_IND_LEN;

  logic [lsfp_pkg::PairW-1:0] pair_q, pair_d;
  logic [7:0]                 acc_q, acc_d;
  logic [RemW-1:0]            rem_q, rem_d;
  logic                       out_valid_q;
  logic [lsfp_pkg::PairW-1:0] pair_index_q;
  lsfp_pkg::rgb_t             even_q, odd_q;
  logic                       last_q;

  logic                       advance;
  logic                       fire;
  logic                       last_pair;
  logic [RemW:0]              rem_odd_sum;
  logic [7:0]                 acc_odd;
  logic [RemW:0]              rem_next_sum;
  logic [lsfp_pkg::PixW-1:0]  even_idx, odd_idx;
  lsfp_pkg::rgb_t             even_c, odd_c;

  function automatic lsfp_pkg::rgb_t pixel_colour(lsfp_pkg::frame_desc_t d,
                                                   logic [7:0] q,
                                                   logic [lsfp_pkg::PixW-1:0] idx);
    lsfp_pkg::rgb_t  c;
    logic [SegW-1:0] p;
    logic            left_on, right_on, in_left, in_right;
    case (d.pattern)
      lsfp_pkg::PAT_RAINBOW: c = lsfp_pkg::colour_wheel(d.hue + q);
      lsfp_pkg::PAT_BREATH:  c = '{red: '0, green: d.level, blue: '0};
      default:               c = '0;
    endcase
    p        = SegW'(idx);
    left_on  = (d.mode == lsfp_pkg::IND_LEFT) || (d.mode == lsfp_pkg::IND_HAZARD);
    right_on = (d.mode == lsfp_pkg::IND_RIGHT) || (d.mode == lsfp_pkg::IND_HAZARD);
    in_right = (p >= SegW'(RightLo)) && (p < SegW'(RightHi));
    in_left  = (p >= SegW'(RightHi)) && (p < SegW'(LeftHi));
    if ((left_on && in_left) || (right_on && in_right)) begin
      c = '{red: '0, green: (d.lit ? lsfp_pkg::ChanFull : '0), blue: '0};
    end
    return c;
  endfunction

  assign advance   = !out_valid_q || out_ready_i;
  assign fire      = advance && head_valid_i;
  assign last_pair = (pair_q == lsfp_pkg::PairW'(Pairs - 1));
  assign pop_o     = fire && last_pair;

  assign even_idx = {pair_q, 1'b0};
  assign odd_idx  = {pair_q, 1'b1};

  always_comb begin
    // Hue offset of the odd pixel: one pixel step beyond the even one.
    rem_odd_sum = {1'b0, rem_q} + (RemW + 1)'(StepR);
    acc_odd     = acc_q + 8'(StepQ);
    if (rem_odd_sum >= (RemW + 1)'(NUM_PIXELS)) begin
      acc_odd = acc_odd + 8'd1;
    end

    even_c = pixel_colour(head_desc_i, acc_q, even_idx);
    odd_c  = '0;
    if ({1'b0, odd_idx} < (lsfp_pkg::PixW + 1)'(NUM_PIXELS)) begin
      odd_c = pixel_colour(head_desc_i, acc_odd, odd_idx);
    end

    // Advance the even pixel by two pixel steps.
    rem_next_sum = {1'b0, rem_q} + (RemW + 1)'(Step2R);
    pair_d = pair_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (fire) begin
      if (last_pair) begin
        pair_d = '0;
        acc_d  = '0;
        rem_d  = '0;
      end else begin
        pair_d = pair_q + 1'b1;
        if (rem_next_sum >= (RemW + 1)'(NUM_PIXELS)) begin
          rem_d = RemW'(rem_next_sum - (RemW + 1)'(NUM_PIXELS));
          acc_d = acc_q + 8'(Step2Q) + 8'd1;
        end else begin
          rem_d = rem_next_sum[RemW-1:0];
          acc_d = acc_q + 8'(Step2Q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q      <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pair_q <= pair_d;
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      if (advance) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pair_index_q <= pair_q;
      even_q       <= even_c;
      odd_q        <= odd_c;
      last_q       <= last_pair;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pair_index_o = pair_index_q;
  assign red_even_o   = even_q.red;
  assign green_even_o = even_q.green;
  assign blue_even_o  = even_q.blue;
  assign red_odd_o    = odd_q.red;
  assign green_odd_o  = odd_q.green;
  assign blue_odd_o   = odd_q.blue;
  assign last_pair_o  = last_q;

endmodule

// ===== src/led_strip_frame_pattern.sv =====
// LED strip frame pattern generator.
// Each request on the input channel (in_valid_i / in_ready_o) is one frame
// tick: it selects the pattern, the indicator mode and the milliseconds since
// the previous tick. The block answers with the whole strip as pixel pairs on
// the output channel (out_valid_o / out_ready_i), one pair per request there,
// with last_pair_o marking the final pair of the frame.
// The first pair of a frame passes through the queue and then the painter's
// output register before it is shown. The pairs then follow at one per
// cycle while the receiver takes them; a frame is (NUM_PIXELS+1)/2 pairs,
// 58 with the default strip, all issued by the single pair painter.
// The front end updates the animation and blink state as soon as a tick is
// taken and places a frame description in a two-entry queue, so new ticks are
// accepted while an earlier frame is still being painted or waits on the
// receiver. When the receiver stalls, the current pair is held and the queue
// fills; in_ready_o drops only once the queue is full.
// After reset the pattern is off, the flash is lit and the blink period is
// 500 ms; blink_period_ms_we_i writes a new period on any clock edge.
module led_strip_frame_pattern #(
  parameter int NUM_PIXELS       = lsfp_pkg::NumPixelsDefault,
  parameter int RIGHT_RUNNER_LEN = lsfp_pkg::RightRunnerLenDefault,
  parameter int RIGHT_IND_LEN    = lsfp_pkg::RightIndLenDefault,
  parameter int LEFT_IND_LEN     = lsfp_pkg::LeftIndLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        blink_period_ms_we_i,
  input  logic [15:0] blink_period_ms_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pattern_request_i,
  input  logic [1:0]  indicator_mode_i,
  input  logic [15:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  pair_index_o,
  output logic [7:0]  red_even_o,
  output logic [7:0]  green_even_o,
  output logic [7:0]  blue_even_o,
  output logic [7:0]  red_odd_o,
  output logic [7:0]  green_odd_o,
  output logic [7:0]  blue_odd_o,
  output logic        last_pair_o
);

  // Frame descriptions travel from the front end to the painter via the queue.
  logic                  push;
  logic                  queue_full;
  logic                  pop;
  logic                  head_valid;
  lsfp_pkg::frame_desc_t push_desc;
  lsfp_pkg::frame_desc_t head_desc;

  lsfp_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .blink_period_ms_we_i (blink_period_ms_we_i),
    .blink_period_ms_i    (blink_period_ms_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .pattern_request_i    (pattern_request_i),
    .indicator_mode_i     (indicator_mode_i),
    .elapsed_ms_i         (elapsed_ms_i),
    .queue_full_i         (queue_full),
    .push_o               (push),
    .push_desc_o          (push_desc)
  );

  lsfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_desc_i  (push_desc),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_desc_o  (head_desc)
  );

  // The painter walks the strip one pair per cycle while the receiver takes them
  // and releases the queue entry when it has issued the final pair of the frame.
  lsfp_back #(
    .NUM_PIXELS       (NUM_PIXELS),
    .RIGHT_RUNNER_LEN (RIGHT_RUNNER_LEN),
    .RIGHT_IND_LEN    (RIGHT_IND_LEN),
    .LEFT_IND_LEN     (LEFT_IND_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pair_index_o (pair_index_o),
    .red_even_o   (red_even_o),
    .green_even_o (green_even_o),
    .blue_even_o  (blue_even_o),
    .red_odd_o    (red_odd_o),
    .green_odd_o  (green_odd_o),
    .blue_odd_o   (blue_odd_o),
    .last_pair_o  (last_pair_o)
  );

endmodule
